// ===== hdl/tspfa_pkg.sv =====
package tspfa_pkg;

	localparam int ADDR_W          = 32;
	localparam int SMALL_SHIFT     = 12;
	localparam int LARGE_SHIFT     = 22;
	localparam int SPN_W           = ADDR_W - SMALL_SHIFT;
	localparam int LPN_W           = ADDR_W - LARGE_SHIFT;
	localparam int SPL_W           = LARGE_SHIFT - SMALL_SHIFT;
	localparam int SMALL_PER_LARGE = 1 << SPL_W;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam logic KIND_FREE  = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	// Source of the value loaded into the result register.
	localparam int OSEL_W = 3;
	localparam logic [OSEL_W-1:0] OSEL_NONE  = 3'd0;
	localparam logic [OSEL_W-1:0] OSEL_OK    = 3'd1;
	localparam logic [OSEL_W-1:0] OSEL_OOM   = 3'd2;
	localparam logic [OSEL_W-1:0] OSEL_FULL  = 3'd3;
	localparam logic [OSEL_W-1:0] OSEL_LDATA = 3'd4;
	localparam logic [OSEL_W-1:0] OSEL_SDATA = 3'd5;

	typedef struct packed {
		logic              capture;
		logic              push;
		logic              pop_large;
		logic              pop_small;
		logic              split_push;
		logic [OSEL_W-1:0] out_sel;
	} tspfa_cmd_t;

	typedef struct packed {
		logic kind;
		logic is_large;
		logic large_empty;
		logic large_full;
		logic small_empty;
		logic small_full;
		logic split_last;
		logic out_free;
	} tspfa_sts_t;

endpackage

// ===== hdl/tspfa_req_if.sv =====
interface tspfa_req_if import tspfa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic              is_large;
	logic [ADDR_W-1:0] page_address;

	modport source (output valid, kind, is_large, page_address, input ready);
	modport sink (input valid, kind, is_large, page_address, output ready);
endinterface

// ===== hdl/tspfa_rsp_if.sv =====
interface tspfa_rsp_if import tspfa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   granted_address;
	logic [STATUS_W-1:0] status;

	modport source (output valid, granted_address, status, input ready);
	modport sink (input valid, granted_address, status, output ready);
endinterface

// ===== hdl/tspfa_ctrl.sv =====
module tspfa_ctrl import tspfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  tspfa_sts_t sts,
	output tspfa_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_POP_L = 3'd2;
	localparam logic [2:0] S_POP_S = 3'd3;
	localparam logic [2:0] S_SPLIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.kind == KIND_FREE) begin
					if (sts.out_free) begin
						if (sts.is_large ? sts.large_full : sts.small_full) begin
							cmd.out_sel = OSEL_FULL;
						end else begin
							cmd.push    = 1'b1;
							cmd.out_sel = OSEL_OK;
						end
						state_d = S_IDLE;
					end
				end else if (sts.is_large) begin
					if (!sts.large_empty) begin
						cmd.pop_large = 1'b1;
						state_d       = S_POP_L;
					end else if (sts.out_free) begin
						cmd.out_sel = OSEL_OOM;
						state_d     = S_IDLE;
					end
				end else begin
					if (!sts.small_empty) begin
						cmd.pop_small = 1'b1;
						state_d       = S_POP_S;
					end else if (!sts.large_empty) begin
						// Take the top large page apart into small pages.
						cmd.pop_large = 1'b1;
						state_d       = S_SPLIT;
					end else if (sts.out_free) begin
						cmd.out_sel = OSEL_OOM;
						state_d     = S_IDLE;
					end
				end
			end
			S_POP_L: begin
				if (sts.out_free) begin
					cmd.out_sel = OSEL_LDATA;
					state_d     = S_IDLE;
				end
			end
			S_POP_S: begin
				if (sts.out_free) begin
					cmd.out_sel = OSEL_SDATA;
					state_d     = S_IDLE;
				end
			end
			S_SPLIT: begin
				cmd.split_push = 1'b1;
				// After the last push the small stack is served as usual.
				if (sts.split_last) begin
					state_d = S_EXEC;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/tspfa_dp.sv =====
module tspfa_dp import tspfa_pkg::*; #(
	parameter int LARGE_DEPTH = 256,
	parameter int SMALL_DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tspfa_cmd_t          cmd,
	output tspfa_sts_t          sts,
	input  logic                kind,
	input  logic                is_large,
	input  logic [ADDR_W-1:0]   page_address,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output logic [ADDR_W-1:0]   granted_address,
	output logic [STATUS_W-1:0] status
);

	localparam int LCNT_W = $clog2(LARGE_DEPTH + 1);
	localparam int SCNT_W = $clog2(SMALL_DEPTH + 1);
	localparam int LIDX_W = (LARGE_DEPTH > 1) ? $clog2(LARGE_DEPTH) : 1;
	localparam int SIDX_W = $clog2(SMALL_DEPTH);

	logic [LPN_W-1:0] large_mem [LARGE_DEPTH];
	logic [SPN_W-1:0] small_mem [SMALL_DEPTH];

	logic              kind_q;
	logic              large_q;
	logic [SPN_W-1:0]  spn_q;
	logic [LCNT_W-1:0] lcount_q;
	logic [SCNT_W-1:0] scount_q;
	logic [LPN_W-1:0]  lrd_q;
	logic [SPN_W-1:0]  srd_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [LCNT_W-1:0] lcount_dec;
	logic [SCNT_W-1:0] scount_dec;
	logic [SPN_W-1:0]  split_pn;
	logic              out_free;

	assign lcount_dec = lcount_q - LCNT_W'(1);
	assign scount_dec = scount_q - SCNT_W'(1);
	// Split pages are numbered by the small fill level, which starts at zero.
	assign split_pn   = {lrd_q, scount_q[SPL_W-1:0]};
	assign out_free   = !out_valid_q || rsp_ready;

	assign sts.kind        = kind_q;
	assign sts.is_large    = large_q;
	assign sts.large_empty = (lcount_q == '0);
	assign sts.large_full  = (lcount_q == LCNT_W'(LARGE_DEPTH));
	assign sts.small_empty = (scount_q == '0);
	assign sts.small_full  = (scount_q == SCNT_W'(SMALL_DEPTH));
	assign sts.split_last  = (scount_q == SCNT_W'(SMALL_PER_LARGE - 1));
	assign sts.out_free    = out_free;

	assign rsp_valid       = out_valid_q;
	assign granted_address = out_addr_q;
	assign status          = out_status_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			large_q <= is_large;
			spn_q   <= page_address[ADDR_W-1:SMALL_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && large_q) begin
			large_mem[lcount_q[LIDX_W-1:0]] <= spn_q[SPN_W-1:SPL_W];
		end
		if (cmd.pop_large) begin
			lrd_q <= large_mem[lcount_dec[LIDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !large_q) begin
			small_mem[scount_q[SIDX_W-1:0]] <= spn_q;
		end else if (cmd.split_push) begin
			small_mem[scount_q[SIDX_W-1:0]] <= split_pn;
		end
		if (cmd.pop_small) begin
			srd_q <= small_mem[scount_dec[SIDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcount_q <= '0;
			scount_q <= '0;
		end else begin
			if (cmd.push && large_q) begin
				lcount_q <= lcount_q + LCNT_W'(1);
			end else if (cmd.pop_large) begin
				lcount_q <= lcount_dec;
			end
			if ((cmd.push && !large_q) || cmd.split_push) begin
				scount_q <= scount_q + SCNT_W'(1);
			end else if (cmd.pop_small) begin
				scount_q <= scount_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_sel != OSEL_NONE) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			OSEL_OK: begin
				out_addr_q   <= '0;
				out_status_q <= ST_OK;
			end
			OSEL_OOM: begin
				out_addr_q   <= '0;
				out_status_q <= ST_OOM;
			end
			OSEL_FULL: begin
				out_addr_q   <= '0;
				out_status_q <= ST_FULL;
			end
			OSEL_LDATA: begin
				out_addr_q   <= {lrd_q, {LARGE_SHIFT{1'b0}}};
				out_status_q <= ST_OK;
			end
			OSEL_SDATA: begin
				out_addr_q   <= {srd_q, {SMALL_SHIFT{1'b0}}};
				out_status_q <= ST_OK;
			end
			default: begin
				out_addr_q   <= out_addr_q;
				out_status_q <= out_status_q;
			end
		endcase
	end

endmodule

// ===== hdl/two_size_page_frame_allocator_unit.sv =====
// Each request is captured on accept. A free or an out-of-memory answer is then loaded into the
// result register; a pop first does a registered read of its single-port stack memory, and a small
// allocate that splits a large page first makes 1024 stack writes and then pops the small stack.
// A new request is taken only after the last result is loaded; a stalled result port holds the unit until it is taken.
// Reset clears both fill counts, the controller state and the result valid; the stack memories
// are not cleared, since only entries below the fill count are ever read.
module two_size_page_frame_allocator_unit import tspfa_pkg::*; #(
	parameter int LARGE_DEPTH = 256,
	parameter int SMALL_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	tspfa_req_if.sink   req,
	tspfa_rsp_if.source rsp
);

	// The controller sequences each request: capture, stack access, optional split
	// walk, and the load of the result register. The datapath owns both stacks,
	// their fill counts and the result register that decouples the result port.
	tspfa_cmd_t cmd;
	tspfa_sts_t sts;

	tspfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath stores page numbers only; the offset bits below the small page size are dropped when
	// the request is captured, and a freed large page drops its lower page-number bits when pushed.
	tspfa_dp #(
		.LARGE_DEPTH (LARGE_DEPTH),
		.SMALL_DEPTH (SMALL_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (req.kind),
		.is_large        (req.is_large),
		.page_address    (req.page_address),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.granted_address (rsp.granted_address),
		.status          (rsp.status)
	);

endmodule
